### hw/rtl/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge of clk_i outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The antecedent at an edge implies the consequent at the same edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hw/rtl/hcpa_pkg.sv
// Shared types and constants of the high-current port allocator.
package hcpa_pkg;

  localparam int unsigned DEF_NUM_PORTS = 8;
  localparam int unsigned PORT_W        = 3;
  localparam int unsigned CLAIM_W       = 8;
  localparam int unsigned LIMIT_W       = 4;
  localparam int unsigned PDO_W         = 32;

  // Fixed supply object fields.
  localparam logic [1:0]  FIXED_SUPPLY_TYPE = 2'b00;
  localparam int unsigned FIXED_5V_MV       = 5000;
  localparam int unsigned HALF_CURRENT_MA   = 1500;
  localparam int unsigned PDO_MV_UNIT       = 50;
  localparam int unsigned PDO_MA_UNIT       = 10;
  localparam logic [9:0]  PDO_VOLT_CODE     = 10'(FIXED_5V_MV / PDO_MV_UNIT);
  localparam logic [9:0]  PDO_CURR_CODE     = 10'(HALF_CURRENT_MA / PDO_MA_UNIT);

  typedef enum logic {
    CMD_EVALUATE = 1'b0,
    CMD_REMOVE   = 1'b1
  } cmd_e;

  typedef struct packed {
    logic               offered_3a;
    logic               grant_valid;
    logic [PORT_W-1:0]  grant_port;
    logic               overcount_error;
    logic [CLAIM_W-1:0] claimed_ports;
  } result_t;

endpackage

### hw/rtl/high_current_port_allocator.sv
// Top level of the high-current port allocator: handshakes, state and result register.
`include "assert_macros.svh"

// Items enter an input register, are evaluated against the request and slot masks by one
// pass of combinational logic (mask update plus an eight-way lowest-port encoder), and the
// result is held in an output register. The block takes one item per clock cycle as long
// as results are taken; an item's result is registered once the output register is free.
// The slot limit is written through the configuration channel, which is always ready,
// and must only change while no item is in flight. There is no clearing pass after reset.
module high_current_port_allocator #(
  parameter int unsigned NUM_PORTS = hcpa_pkg::DEF_NUM_PORTS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hcpa_pkg::LIMIT_W-1:0] cfg_slot_limit_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [hcpa_pkg::PORT_W-1:0]  port_i,
  input  logic [hcpa_pkg::PDO_W-1:0]   sink_pdo_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         port_offered_3a_o,
  output logic                         grant_valid_o,
  output logic [hcpa_pkg::PORT_W-1:0]  grant_port_o,
  output logic                         overcount_error_o,
  output logic [hcpa_pkg::CLAIM_W-1:0] claimed_ports_o
);

  localparam int unsigned MaskW = (NUM_PORTS < hcpa_pkg::CLAIM_W) ?
                                  NUM_PORTS : hcpa_pkg::CLAIM_W;

  logic [hcpa_pkg::LIMIT_W-1:0] slot_limit_q;
  logic [MaskW-1:0]             req_q, req_d;
  logic [MaskW-1:0]             hold_q, hold_d;
  logic [hcpa_pkg::LIMIT_W-1:0] count_q, count_d;

  logic                         s1_valid_q;
  logic                         s1_command_q;
  logic [hcpa_pkg::PORT_W-1:0]  s1_port_q;
  logic [hcpa_pkg::PDO_W-1:0]   s1_pdo_q;

  logic                         out_valid_q;
  hcpa_pkg::result_t            result_q, result_d;

  logic                         out_adv;
  logic                         s1_fire;

  assign out_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || out_adv;
  assign s1_fire     = s1_valid_q && out_adv;
  assign cfg_ready_o = 1'b1;

  hcpa_step #(
    .NUM_PORTS (NUM_PORTS)
  ) u_step (
    .command_i    (s1_command_q),
    .port_i       (s1_port_q),
    .sink_pdo_i   (s1_pdo_q),
    .slot_limit_i (slot_limit_q),
    .req_i        (req_q),
    .hold_i       (hold_q),
    .count_i      (count_q),
    .req_o        (req_d),
    .hold_o       (hold_d),
    .count_o      (count_d),
    .result_o     (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_limit_q <= '0;
      req_q        <= '0;
      hold_q       <= '0;
      count_q      <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        slot_limit_q <= cfg_slot_limit_i;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        req_q   <= req_d;
        hold_q  <= hold_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_command_q <= command_i;
      s1_port_q    <= port_i;
      s1_pdo_q     <= sink_pdo_i;
    end
    if (s1_fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign port_offered_3a_o = result_q.offered_3a;
  assign grant_valid_o     = result_q.grant_valid;
  assign grant_port_o      = result_q.grant_port;
  assign overcount_error_o = result_q.overcount_error;
  assign claimed_ports_o   = result_q.claimed_ports;

  `ASSERT_ALWAYS(a_count_matches_mask, count_q == $countones(hold_q), "slot count out of step with holding mask")
  `ASSERT_ALWAYS(a_hold_implies_req, (hold_q & ~req_q) == '0, "a port holds a slot without requesting")
  `ASSERT_IMPLIES(a_grant_is_held, out_valid_o && grant_valid_o, claimed_ports_o[grant_port_o], "granted port does not hold a slot")
  `ASSERT_IMPLIES(a_error_no_grant, out_valid_o && overcount_error_o, !grant_valid_o, "grant reported together with over-count error")

endmodule

### hw/rtl/hcpa_lowest.sv
// Lowest-set-bit priority encoder over the waiting ports.
module hcpa_lowest #(
  parameter int unsigned W = hcpa_pkg::DEF_NUM_PORTS
) (
  input  logic [W-1:0]                mask_i,
  output logic                        found_o,
  output logic [hcpa_pkg::PORT_W-1:0] index_o
);

  always_comb begin
    index_o = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (mask_i[i]) begin
        index_o = hcpa_pkg::PORT_W'(i);
      end
    end
  end

  assign found_o = |mask_i;

endmodule

### hw/rtl/hcpa_step.sv
// Single-pass update of the request and slot state for one item.
module hcpa_step #(
  parameter int unsigned NUM_PORTS = hcpa_pkg::DEF_NUM_PORTS,
  localparam int unsigned MaskW    = (NUM_PORTS < hcpa_pkg::CLAIM_W) ?
                                     NUM_PORTS : hcpa_pkg::CLAIM_W
) (
  input  logic                         command_i,
  input  logic [hcpa_pkg::PORT_W-1:0]  port_i,
  input  logic [hcpa_pkg::PDO_W-1:0]   sink_pdo_i,
  input  logic [hcpa_pkg::LIMIT_W-1:0] slot_limit_i,
  input  logic [MaskW-1:0]             req_i,
  input  logic [MaskW-1:0]             hold_i,
  input  logic [hcpa_pkg::LIMIT_W-1:0] count_i,
  output logic [MaskW-1:0]             req_o,
  output logic [MaskW-1:0]             hold_o,
  output logic [hcpa_pkg::LIMIT_W-1:0] count_o,
  output hcpa_pkg::result_t            result_o
);

  logic [MaskW-1:0]            sel;
  logic [MaskW-1:0]            waiting;
  logic [MaskW-1:0]            win_sel;
  logic                        win_found;
  logic [hcpa_pkg::PORT_W-1:0] win_idx;
  logic                        in_range;
  logic                        needs;
  logic                        have;

  always_comb begin
    for (int i = 0; i < MaskW; i++) begin
      sel[i] = (port_i == hcpa_pkg::PORT_W'(i));
    end
  end

  always_comb begin
    for (int i = 0; i < MaskW; i++) begin
      win_sel[i] = (win_idx == hcpa_pkg::PORT_W'(i));
    end
  end

  assign in_range = |sel;
  assign needs    = (sink_pdo_i[31:30] == hcpa_pkg::FIXED_SUPPLY_TYPE) &&
                    (sink_pdo_i[19:10] == hcpa_pkg::PDO_VOLT_CODE) &&
                    (sink_pdo_i[9:0] > hcpa_pkg::PDO_CURR_CODE);
  assign have     = |(req_i & hold_i & sel);
  // The departing port's own request is already dropped here.
  assign waiting  = req_i & ~sel & ~hold_i;

  hcpa_lowest #(
    .W (MaskW)
  ) u_lowest (
    .mask_i  (waiting),
    .found_o (win_found),
    .index_o (win_idx)
  );

  always_comb begin
    req_o    = req_i;
    hold_o   = hold_i;
    count_o  = count_i;
    result_o = '0;
    if ((slot_limit_i != '0) && in_range) begin
      if (command_i == hcpa_pkg::CMD_EVALUATE) begin
        if (needs && !have) begin
          req_o = req_i | sel;
          if (count_i < slot_limit_i) begin
            count_o              = count_i + 1'b1;
            hold_o               = hold_i | sel;
            result_o.grant_valid = 1'b1;
            result_o.grant_port  = port_i;
          end
        end
      end else if (|(req_i & sel)) begin
        req_o = req_i & ~sel;
        if (|(hold_i & sel)) begin
          if (count_i > slot_limit_i) begin
            result_o.overcount_error = 1'b1;
            count_o = (count_i != '0) ? count_i - 1'b1 : count_i;
          end else if (win_found) begin
            // The freed slot moves to the waiting port; the count stays.
            hold_o               = hold_i | win_sel;
            result_o.grant_valid = 1'b1;
            result_o.grant_port  = win_idx;
          end else begin
            count_o = (count_i != '0) ? count_i - 1'b1 : count_i;
          end
          hold_o = hold_o & ~sel;
        end
      end
    end
    result_o.offered_3a                = |(hold_o & sel);
    result_o.claimed_ports[MaskW-1:0] = hold_o;
  end

endmodule

### verif/tb_high_current_port_allocator.sv
// Self-checking testbench for the high-current port allocator with a slot-tracking predictor.
`timescale 1ns / 1ps

module tb_high_current_port_allocator;
  import hcpa_pkg::*;

  localparam int unsigned HOLD_CYCLES = 200;

  // Tracks requests and 3 A slots the way the block should, and holds the results still owed.
  class slot_ledger;
    logic [LIMIT_W-1:0] limit;
    logic [CLAIM_W-1:0] req_mask;
    logic [CLAIM_W-1:0] hold_mask;
    int unsigned held;
    result_t owed_results[$];
    int unsigned mismatches;

    function new();
      limit = '0;
      req_mask = '0;
      hold_mask = '0;
      held = 0;
      mismatches = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      limit = value;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    function void note_item(cmd_e cmd, logic [PORT_W-1:0] port, logic [PDO_W-1:0] pdo);
      result_t r;
      logic [CLAIM_W-1:0] bitm;
      logic [CLAIM_W-1:0] waiting;
      logic needs;
      int lowest;
      r = '0;
      bitm = CLAIM_W'(1) << port;
      if (limit != 0) begin
        if (cmd == CMD_EVALUATE) begin
          needs = (pdo[31:30] == FIXED_SUPPLY_TYPE) && (pdo[19:10] == PDO_VOLT_CODE) &&
                  (pdo[9:0] > PDO_CURR_CODE);
          if (needs && (req_mask & hold_mask & bitm) == 0) begin
            req_mask |= bitm;
            if (held < limit) begin
              held++;
              hold_mask |= bitm;
              r.grant_valid = 1'b1;
              r.grant_port = port;
            end
          end
        end else if ((req_mask & bitm) != 0) begin
          req_mask &= ~bitm;
          if ((hold_mask & bitm) != 0) begin
            // A lowered limit leaves too many holders: the freed slot is not passed on.
            if (held > limit) begin
              r.overcount_error = 1'b1;
            end else begin
              waiting = req_mask & ~hold_mask;
              if (waiting != 0) begin
                lowest = 0;
                for (int i = CLAIM_W - 1; i >= 0; i--) begin
                  if (waiting[i]) lowest = i;
                end
                hold_mask[lowest] = 1'b1;
                held++;
                r.grant_valid = 1'b1;
                r.grant_port = PORT_W'(lowest);
              end
            end
            hold_mask &= ~bitm;
            if (held > 0) held--;
          end
        end
      end
      r.offered_3a = hold_mask[port];
      r.claimed_ports = hold_mask;
      owed_results.push_back(r);
    endfunction

    function void check_result(result_t act);
      result_t exp;
      if (owed_results.size() == 0) begin
        $error("unexpected result item: %p", act);
        mismatches++;
        return;
      end
      exp = owed_results.pop_front();
      if (act.offered_3a !== exp.offered_3a) begin
        $error("port_offered_3a: expected %0d, actual %0d", exp.offered_3a, act.offered_3a);
        mismatches++;
      end
      if (act.grant_valid !== exp.grant_valid) begin
        $error("grant_valid: expected %0d, actual %0d", exp.grant_valid, act.grant_valid);
        mismatches++;
      end
      if (act.grant_port !== exp.grant_port) begin
        $error("grant_port: expected %0d, actual %0d", exp.grant_port, act.grant_port);
        mismatches++;
      end
      if (act.overcount_error !== exp.overcount_error) begin
        $error("overcount_error: expected %0d, actual %0d", exp.overcount_error,
               act.overcount_error);
        mismatches++;
      end
      if (act.claimed_ports !== exp.claimed_ports) begin
        $error("claimed_ports: expected %02h, actual %02h", exp.claimed_ports,
               act.claimed_ports);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [LIMIT_W-1:0] cfg_slot_limit_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               command_i;
  logic [PORT_W-1:0]  port_i;
  logic [PDO_W-1:0]   sink_pdo_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               port_offered_3a_o;
  logic               grant_valid_o;
  logic [PORT_W-1:0]  grant_port_o;
  logic               overcount_error_o;
  logic [CLAIM_W-1:0] claimed_ports_o;

  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_off_req;

  slot_ledger ledger = new();

  high_current_port_allocator i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_slot_limit_i  (cfg_slot_limit_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .port_i            (port_i),
    .sink_pdo_i        (sink_pdo_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .port_offered_3a_o (port_offered_3a_o),
    .grant_valid_o     (grant_valid_o),
    .grant_port_o      (grant_port_o),
    .overcount_error_o (overcount_error_o),
    .claimed_ports_o   (claimed_ports_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [PDO_W-1:0] fixed_pdo(logic [9:0] volt, logic [9:0] cur);
    return {FIXED_SUPPLY_TYPE, 10'd0, volt, cur};
  endfunction

  // Mostly sinks that want 3 A, with near misses and pure noise mixed in.
  function automatic logic [PDO_W-1:0] random_pdo();
    logic [9:0] volt;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      6: begin
        return {FIXED_SUPPLY_TYPE, 10'($urandom), PDO_VOLT_CODE,
                10'($urandom_range(0, PDO_CURR_CODE))};
      end
      7: begin
        return {2'($urandom_range(1, 3)), 30'($urandom)};
      end
      8: begin
        volt = 10'($urandom);
        if (volt == PDO_VOLT_CODE) volt = volt + 10'd1;
        return {FIXED_SUPPLY_TYPE, 10'($urandom), volt, 10'($urandom)};
      end
      9: begin
        return PDO_W'($urandom);
      end
      default: begin
        return {FIXED_SUPPLY_TYPE, 10'($urandom), PDO_VOLT_CODE,
                10'($urandom_range(PDO_CURR_CODE + 1, 1023))};
      end
    endcase
  endfunction

  task automatic send_item(cmd_e cmd, logic [PORT_W-1:0] port, logic [PDO_W-1:0] pdo);
    int unsigned gap;
    @(negedge clk_i);
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    port_i     <= port;
    sink_pdo_i <= pdo;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    ledger.note_item(cmd, port, pdo);
  endtask

  // Stops offering items and waits until every owed result has been taken.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i      <= 1'b1;
    cfg_slot_limit_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    ledger.set_limit(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random(int unsigned count);
    cmd_e cmd;
    for (int unsigned n = 0; n < count; n++) begin
      cmd = ($urandom_range(0, 99) < 55) ? CMD_EVALUATE : CMD_REMOVE;
      send_item(cmd, PORT_W'($urandom_range(0, DEF_NUM_PORTS - 1)), random_pdo());
    end
  endtask

  always @(posedge clk_i) begin
    result_t act;
    if (rst_ni && out_valid_o && out_ready_i) begin
      act.offered_3a      = port_offered_3a_o;
      act.grant_valid     = grant_valid_o;
      act.grant_port      = grant_port_o;
      act.overcount_error = overcount_error_o;
      act.claimed_ports   = claimed_ports_o;
      ledger.check_result(act);
    end
  end

  initial begin : result_sink
    int unsigned gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        gap = $urandom_range(1, 12);
        repeat (gap) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    logic [LIMIT_W-1:0] phase_limits[12];
    phase_limits = '{4'd1, 4'd8, 4'd2, 4'd0, 4'd3, 4'd8, 4'd1, 4'd5, 4'd4, 4'd7, 4'd6, 4'd2};
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_slot_limit_i = '0;
    in_valid_i       = 1'b0;
    command_i        = CMD_EVALUATE;
    port_i           = '0;
    sink_pdo_i       = '0;
    tx_idle_en       = 1'b1;
    rx_idle_en       = 1'b1;
    hold_off_req     = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The limit is zero out of reset, so these items must change nothing.
    send_item(CMD_EVALUATE, 3'd0, fixed_pdo(PDO_VOLT_CODE, 10'd300));
    send_item(CMD_REMOVE, 3'd7, fixed_pdo(PDO_VOLT_CODE, 10'd300));
    send_item(CMD_EVALUATE, 3'd7, 32'hFFFF_FFFF);

    write_limit(4'd2);
    send_item(CMD_EVALUATE, 3'd0, 32'h0000_0000);
    send_item(CMD_EVALUATE, 3'd7, 32'hFFFF_FFFF);
    // Exactly 1.5 A does not qualify; one step above it does.
    send_item(CMD_EVALUATE, 3'd1, fixed_pdo(PDO_VOLT_CODE, PDO_CURR_CODE));
    send_item(CMD_EVALUATE, 3'd1, fixed_pdo(PDO_VOLT_CODE, PDO_CURR_CODE + 10'd1));
    send_item(CMD_EVALUATE, 3'd1, fixed_pdo(PDO_VOLT_CODE, 10'd400));
    send_item(CMD_EVALUATE, 3'd2, fixed_pdo(PDO_VOLT_CODE - 10'd1, 10'd300));
    send_item(CMD_EVALUATE, 3'd2, fixed_pdo(PDO_VOLT_CODE + 10'd1, 10'd300));
    send_item(CMD_EVALUATE, 3'd0, fixed_pdo(PDO_VOLT_CODE, 10'd1023));
    // Both slots are taken now, so these two only register as waiting.
    send_item(CMD_EVALUATE, 3'd7, fixed_pdo(PDO_VOLT_CODE, 10'd300) | 32'h3FF0_0000);
    send_item(CMD_EVALUATE, 3'd5, fixed_pdo(PDO_VOLT_CODE, 10'd200));
    send_item(CMD_REMOVE, 3'd3, 32'hFFFF_FFFF);
    send_item(CMD_REMOVE, 3'd7, 32'h0000_0000);
    send_item(CMD_REMOVE, 3'd1, 32'h0000_0000);
    send_item(CMD_REMOVE, 3'd0, 32'h0000_0000);

    write_limit(4'd3);
    send_item(CMD_EVALUATE, 3'd2, fixed_pdo(PDO_VOLT_CODE, 10'd300));
    send_item(CMD_EVALUATE, 3'd3, fixed_pdo(PDO_VOLT_CODE, 10'd300));
    send_item(CMD_EVALUATE, 3'd4, fixed_pdo(PDO_VOLT_CODE, 10'd300));
    // Lowering the limit under the held count makes holders' detaches over-count while the count exceeds it.
    write_limit(4'd1);
    send_item(CMD_REMOVE, 3'd2, 32'h0000_0000);
    send_item(CMD_REMOVE, 3'd4, 32'h0000_0000);
    send_item(CMD_REMOVE, 3'd3, 32'h0000_0000);
    send_item(CMD_REMOVE, 3'd5, 32'h0000_0000);

    for (int p = 0; p < 12; p++) begin
      write_limit(phase_limits[p]);
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      if (p == 2) begin
        // The sink holds off while items keep coming, so the block backs up.
        hold_off_req = 1'b1;
        send_random(40);
        send_random(40);
      end else if (p == 11) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_random(80);
      end else if (p == 5) begin
        send_random(40);
        wait_drained();
        send_random(40);
      end else begin
        send_random(80);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (ledger.pending() != 0) begin
      $error("%0d result items never arrived", ledger.pending());
      ledger.mismatches++;
    end
    if (ledger.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
